>>> design/fps_pkg.sv
// Package for the flight phase sequencer: shared types, register reset values,
// phase codes and the constants of the scan window divider.
// No dependencies.
package fps_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASELINE_LIGHT     = 3'd0,
        CFG_ARM_TIME           = 3'd1,
        CFG_ABORT_TIME         = 3'd2,
        CFG_FIRE_DURATION      = 3'd3,
        CFG_LAUNCH_COUNT_LIMIT = 3'd4,
        CFG_LAND_COUNT_LIMIT   = 3'd5,
        CFG_HEIGHT_THRESHOLD   = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] baseline_light;
        logic [31:0] arm_time;
        logic [31:0] abort_time;
        logic [31:0] fire_duration;
        logic [7:0]  launch_count_limit;
        logic [7:0]  land_count_limit;
        logic [22:0] height_threshold;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        baseline_light:     16'd0,
        arm_time:           32'd2000000,
        abort_time:         32'd2400000,
        fire_duration:      32'd10000,
        launch_count_limit: 8'd3,
        land_count_limit:   8'd15,
        height_threshold:   23'd500
    };

    // Internal phase state, one-hot.
    typedef enum logic [3:0] {
        PH_STARTED   = 4'b0001,
        PH_IN_ROCKET = 4'b0010,
        PH_FLYING    = 4'b0100,
        PH_LANDED    = 4'b1000
    } phase_t;

    // Phase codes as they appear on the result.
    localparam logic [1:0] PHASE_CODE_STARTED   = 2'd0;
    localparam logic [1:0] PHASE_CODE_IN_ROCKET = 2'd1;
    localparam logic [1:0] PHASE_CODE_FLYING    = 2'd2;
    localparam logic [1:0] PHASE_CODE_LANDED    = 2'd3;

    localparam logic [7:0] LAND_ANGLE  = 8'd30;
    localparam logic [7:0] ABORT_ANGLE = 8'd90;
    localparam logic [7:0] COUNT_MAX   = 8'hFF;

    // time / 60000 is computed as ((time >> 5) * WIN_RECIP) >> WIN_SHIFT,
    // exact for every 32-bit time since 60000 = 32 * 1875.
    localparam int         WIN_PRE_SHIFT = 5;
    localparam int         WIN_SHIFT     = 38;
    localparam logic [27:0] WIN_RECIP    = 28'd146601551;
    localparam int         WIN_Q_W       = 17;

    // q / 10 for a 17-bit q, as (q * DEC_RECIP) >> DEC_SHIFT.
    localparam int          DEC_SHIFT = 21;
    localparam logic [17:0] DEC_RECIP = 18'd209716;
    localparam int          DEC_Q_W   = 14;

    typedef struct packed {
        logic [31:0]        time_ms;
        logic [15:0]        light_level;
        logic signed [23:0] height_change;
    } sample_t;

    typedef struct packed {
        logic [1:0] phase;
        logic       fire_on;
        logic       servo_set;
        logic [7:0] servo_angle;
        logic       orient_request;
        logic       scan_request;
    } result_t;

    function automatic logic [1:0] phase_code(input phase_t ph);
        logic [1:0] code;
        case (ph)
            PH_STARTED:   code = PHASE_CODE_STARTED;
            PH_IN_ROCKET: code = PHASE_CODE_IN_ROCKET;
            PH_FLYING:    code = PHASE_CODE_FLYING;
            PH_LANDED:    code = PHASE_CODE_LANDED;
            default:      code = PHASE_CODE_STARTED;
        endcase
        return code;
    endfunction

endpackage

>>> design/fps_cfg_regs.sv
// Configuration register file of the flight phase sequencer.
// Depends on fps_pkg.
module fps_cfg_regs
    import fps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        case (cfg_index)
            CFG_BASELINE_LIGHT:     cfg_next.baseline_light     = cfg_data[15:0];
            CFG_ARM_TIME:           cfg_next.arm_time           = cfg_data;
            CFG_ABORT_TIME:         cfg_next.abort_time         = cfg_data;
            CFG_FIRE_DURATION:      cfg_next.fire_duration      = cfg_data;
            CFG_LAUNCH_COUNT_LIMIT: cfg_next.launch_count_limit = cfg_data[7:0];
            CFG_LAND_COUNT_LIMIT:   cfg_next.land_count_limit   = cfg_data[7:0];
            CFG_HEIGHT_THRESHOLD:   cfg_next.height_threshold   = cfg_data[22:0];
            default:                cfg_next = cfg_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> design/fps_window_div.sv
// Scan window detector: decides whether (time / 60000) % 10 is zero, using
// a registered reciprocal multiply followed by a decimal check.
// Depends on fps_pkg.
module fps_window_div
    import fps_pkg::*;
(
    input  logic        clk,
    input  logic        load,
    input  logic [31:0] time_ms,
    output logic        scan_window
);

    logic [31-WIN_PRE_SHIFT:0] scaled;
    logic [54:0]               win_prod;
    logic [WIN_Q_W-1:0]        minutes_next;
    logic [WIN_Q_W-1:0]        minutes_reg;
    logic [34:0]               dec_prod;
    logic [DEC_Q_W-1:0]        tens;
    logic [WIN_Q_W-1:0]        tens_x10;

    // First half: whole minutes of the mission time.
    assign scaled       = time_ms[31:WIN_PRE_SHIFT];
    assign win_prod     = 55'(scaled) * 55'(WIN_RECIP);
    assign minutes_next = win_prod[WIN_SHIFT+WIN_Q_W-1:WIN_SHIFT];

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            minutes_reg <= minutes_next;
        end
    end

    // Second half: the minute count is a multiple of ten.
    assign dec_prod    = 35'(minutes_reg) * 35'(DEC_RECIP);
    assign tens        = dec_prod[DEC_SHIFT+DEC_Q_W-1:DEC_SHIFT];
    assign tens_x10    = WIN_Q_W'({tens, 3'b000}) + WIN_Q_W'({tens, 1'b0});
    assign scan_window = (minutes_reg == tens_x10);

endmodule

>>> design/fps_phase_core.sv
// Phase state machine of the flight phase sequencer: counter, fire timer,
// servo commands and landed requests for one sample per step.
// Depends on fps_pkg.
module fps_phase_core
    import fps_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  sample_t sample,
    input  cfg_t    cfg,
    input  logic    scan_window,
    output result_t result
);

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [7:0]  count_reg;
    logic [7:0]  count_next;
    logic [31:0] fire_time_reg;
    logic [31:0] fire_time_next;
    logic        fire_level_reg;
    logic        fire_level_next;

    logic [19:0]        light_x10;
    logic [19:0]        base_x9;
    logic               dark;
    logic signed [23:0] threshold_s;
    logic               still;
    logic [7:0]         count_inc;
    logic               fire_window;
    logic               servo_set;
    logic [7:0]         servo_angle;
    logic               orient_request;
    logic               scan_request;

    assign light_x10   = 20'({sample.light_level, 3'b000}) + 20'({sample.light_level, 1'b0});
    assign base_x9     = 20'({cfg.baseline_light, 3'b000}) + 20'(cfg.baseline_light);
    assign dark        = (light_x10 <= base_x9);
    assign threshold_s = signed'({1'b0, cfg.height_threshold});
    assign still       = (sample.height_change < threshold_s);
    assign count_inc   = (count_reg == COUNT_MAX) ? count_reg : count_reg + 8'd1;
    assign fire_window = ((sample.time_ms - fire_time_reg) < cfg.fire_duration);

    always_comb
    begin
        phase_next      = phase_reg;
        count_next      = count_reg;
        fire_time_next  = fire_time_reg;
        fire_level_next = fire_level_reg;
        servo_set       = 1'b0;
        servo_angle     = 8'd0;
        orient_request  = 1'b0;
        scan_request    = 1'b0;

        case (phase_reg)
            PH_STARTED:
            begin
                if (sample.time_ms >= cfg.arm_time)
                begin
                    phase_next = PH_IN_ROCKET;
                end
            end
            PH_IN_ROCKET:
            begin
                // The launch test sees the count before this sample is counted.
                if (count_reg > cfg.launch_count_limit)
                begin
                    fire_time_next  = sample.time_ms;
                    fire_level_next = (cfg.fire_duration != 32'd0);
                    phase_next      = PH_FLYING;
                end
                count_next = dark ? 8'd0 : count_inc;
            end
            PH_FLYING:
            begin
                fire_level_next = fire_window;
                count_next      = still ? count_inc : 8'd0;
                if (count_next > cfg.land_count_limit)
                begin
                    phase_next  = PH_LANDED;
                    servo_set   = 1'b1;
                    servo_angle = LAND_ANGLE;
                end
            end
            PH_LANDED:
            begin
                fire_level_next = fire_window;
                orient_request  = 1'b1;
                scan_request    = scan_window;
            end
            default:
            begin
                phase_next = PH_STARTED;
            end
        endcase

        // Abort looks at the phase after this pass's own action.
        if ((sample.time_ms > cfg.abort_time) && (phase_next != PH_LANDED))
        begin
            phase_next  = PH_LANDED;
            servo_set   = 1'b1;
            servo_angle = ABORT_ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_STARTED;
            count_reg      <= 8'd0;
            fire_time_reg  <= 32'd0;
            fire_level_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            count_reg      <= count_next;
            fire_time_reg  <= fire_time_next;
            fire_level_reg <= fire_level_next;
        end
    end

    assign result = '{
        phase:          phase_code(phase_next),
        fire_on:        fire_level_next,
        servo_set:      servo_set,
        servo_angle:    servo_angle,
        orient_request: orient_request,
        scan_request:   scan_request
    };

endmodule

>>> design/flight_phase_sequencer.sv
// Top level of the flight phase sequencer: input stage, window stage, phase
// state machine and result register. Depends on fps_pkg, fps_cfg_regs,
// fps_window_div and fps_phase_core.
//
//   Channel   Direction  Handshake            Payload
//   input     in         in_valid / in_stall  time_ms, light_level, height_change
//   result    out        out_valid/out_stall  phase, fire_on, servo_set,
//                                             servo_angle, orient_request,
//                                             scan_request
//   config    in         cfg_we               cfg_index, cfg_data
//
// One beat is accepted per cycle while the pipeline is not held, and each
// beat yields exactly one result beat, passing s1, s2 and the result register
// before it is offered. The depth is set by the reciprocal multiply for the
// scan window, which is registered ahead of the phase state machine.
// The whole pipeline advances together; it holds only while a result beat
// waits with out_stall high, and in_stall follows that condition.
// rst_n clears the pipeline valid bits, the phase state and the registers to
// their defaults; no clearing pass is needed.
module flight_phase_sequencer
    import fps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [31:0]           time_ms,
    input  logic [15:0]           light_level,
    input  logic signed [23:0]    height_change,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            phase,
    output logic                  fire_on,
    output logic                  servo_set,
    output logic [7:0]            servo_angle,
    output logic                  orient_request,
    output logic                  scan_request,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    logic    advance;
    logic    step;
    logic    scan_window;
    result_t result;

    logic    s1_valid_reg;
    sample_t s1_sample_reg;
    logic    s2_valid_reg;
    sample_t s2_sample_reg;
    logic    out_valid_reg;
    result_t out_result_reg;

    // A result beat that is held blocks the whole pipeline; otherwise every
    // stage moves on each cycle, bubbles included.
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = !advance;
    assign step     = advance && s2_valid_reg;

    fps_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The minute count is loaded alongside the second stage so that its
    // window flag lines up with the sample in s2_sample_reg.
    fps_window_div u_window_div (
        .clk         (clk),
        .load        (advance),
        .time_ms     (s1_sample_reg.time_ms),
        .scan_window (scan_window)
    );

    fps_phase_core u_phase_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .sample      (s2_sample_reg),
        .cfg         (cfg),
        .scan_window (scan_window),
        .result      (result)
    );

    // Valid bits of the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_sample_reg <= '{
                time_ms:       time_ms,
                light_level:   light_level,
                height_change: height_change
            };
            s2_sample_reg <= s1_sample_reg;
        end
        if (step)
        begin
            out_result_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign phase          = out_result_reg.phase;
    assign fire_on        = out_result_reg.fire_on;
    assign servo_set      = out_result_reg.servo_set;
    assign servo_angle    = out_result_reg.servo_angle;
    assign orient_request = out_result_reg.orient_request;
    assign scan_request   = out_result_reg.scan_request;

endmodule

>>> design/fps_checker.sv
// Port-level checks of the flight phase sequencer result channel, bound to
// the top level. Depends on fps_pkg and flight_phase_sequencer.
module fps_checker
    import fps_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] phase,
    input logic       servo_set,
    input logic [7:0] servo_angle,
    input logic       orient_request,
    input logic       scan_request
);

    // A held result beat stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat withdrawn while stalled");

    // Every servo command ends the pass in landed.
    a_servo_landed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && servo_set |-> phase == PHASE_CODE_LANDED)
        else $error("servo command outside landed");

    // The angle is one of the two commands, or zero without a command.
    a_servo_angle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (servo_set && (servo_angle == LAND_ANGLE ||
                                     servo_angle == ABORT_ANGLE)) ||
                      (!servo_set && servo_angle == 8'd0))
        else $error("bad servo angle");

    // Landed requests only come from a pass that stays landed.
    a_orient_landed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && orient_request |-> phase == PHASE_CODE_LANDED && !servo_set)
        else $error("orient request outside landed");

    a_scan_orient: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && scan_request |-> orient_request)
        else $error("scan request without orient request");

endmodule

bind flight_phase_sequencer fps_checker u_fps_checker (.*);

>>> dv/flight_phase_sequencer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for flight_phase_sequencer. It flies one mission through
// started, in rocket, flying and landed, and predicts every result beat in-line.
// Depends on fps_pkg and the flight_phase_sequencer RTL.
module flight_phase_sequencer_test;
    import fps_pkg::*;

    // The port is three bits wide, so one index has no register behind it.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 3'd7;

    localparam logic [31:0] TIME_MAX       = 32'hFFFF_FFFF;
    // Launch time near the top of the range, so flying times wrap past zero.
    localparam logic [31:0] LAUNCH_TIME    = 32'hFFFF_FFF0;
    localparam logic [31:0] ARM_MS         = 32'd5_000_000;
    localparam logic [31:0] ABORT_MS       = 32'd1_000_000;
    localparam logic [31:0] SCAN_WINDOW_MS = 32'd60000;
    localparam logic [31:0] SCAN_PERIOD    = 32'd10;
    localparam int          LONG_HOLD_AT     = 300;
    localparam int          LONG_HOLD_CYCLES = 120;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [31:0]        time_ms = '0;
    logic [15:0]        light_level = '0;
    logic signed [23:0] height_change = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         phase;
    logic               fire_on;
    logic               servo_set;
    logic [7:0]         servo_angle;
    logic               orient_request;
    logic               scan_request;
    logic               cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    flight_phase_sequencer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .time_ms        (time_ms),
        .light_level    (light_level),
        .height_change  (height_change),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .phase          (phase),
        .fire_on        (fire_on),
        .servo_set      (servo_set),
        .servo_angle    (servo_angle),
        .orient_request (orient_request),
        .scan_request   (scan_request),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #1 clk = ~clk;

    // Shadow of the register file and of the mission state, as the block
    // should hold them after the last accepted sample beat.
    cfg_t        flight_cfg = CFG_RESET;
    logic [1:0]  phase_now = PHASE_CODE_STARTED;
    logic [7:0]  run_count = '0;
    logic [31:0] fire_start = '0;
    logic        fire_level = 1'b0;

    sample_t pending_samples[$];
    result_t expected_passes[$];

    logic failed = 1'b0;
    int   beats_out = 0;

    // The fire output is on while the time since launch, taken modulo 2^32,
    // is still inside the configured duration.
    function automatic logic fire_window(input logic [31:0] now);
        logic [31:0] since;
        since = now - fire_start;
        return since < flight_cfg.fire_duration;
    endfunction

    // One control-loop pass: the action of the phase held at the start of the
    // pass runs first, then the abort check looks at the phase it left behind.
    function automatic result_t advance_flight(input sample_t s);
        result_t     r;
        logic [31:0] height_ext;
        r = '0;
        height_ext = {{8{s.height_change[23]}}, s.height_change};
        case (phase_now)
            PHASE_CODE_STARTED:
            begin
                if (s.time_ms >= flight_cfg.arm_time)
                    phase_now = PHASE_CODE_IN_ROCKET;
            end
            PHASE_CODE_IN_ROCKET:
            begin
                // Launch reads the count left by earlier samples, not this one.
                if (run_count > flight_cfg.launch_count_limit)
                begin
                    fire_start = s.time_ms;
                    fire_level = fire_window(s.time_ms);
                    phase_now = PHASE_CODE_FLYING;
                end
                // A dark sample is at or below 0.9 of the baseline, done in integers.
                if (32'd10 * s.light_level <= 32'd9 * flight_cfg.baseline_light)
                    run_count = '0;
                else if (run_count != COUNT_MAX)
                    run_count = run_count + 8'd1;
            end
            PHASE_CODE_FLYING:
            begin
                fire_level = fire_window(s.time_ms);
                // The count carries over from the rocket phase. Landing reads it
                // after this sample's update.
                if ($signed(height_ext) < $signed({9'd0, flight_cfg.height_threshold}))
                begin
                    if (run_count != COUNT_MAX)
                        run_count = run_count + 8'd1;
                end
                else
                    run_count = '0;
                if (run_count > flight_cfg.land_count_limit)
                begin
                    phase_now = PHASE_CODE_LANDED;
                    r.servo_set = 1'b1;
                    r.servo_angle = LAND_ANGLE;
                end
            end
            default:
            begin
                fire_level = fire_window(s.time_ms);
                r.orient_request = 1'b1;
                r.scan_request = ((s.time_ms / SCAN_WINDOW_MS) % SCAN_PERIOD) == 32'd0;
            end
        endcase
        // A landing on this very pass already counts as landed, so no abort.
        if (s.time_ms > flight_cfg.abort_time && phase_now != PHASE_CODE_LANDED)
        begin
            phase_now = PHASE_CODE_LANDED;
            r.servo_set = 1'b1;
            r.servo_angle = ABORT_ANGLE;
        end
        r.phase = phase_now;
        r.fire_on = fire_level;
        return r;
    endfunction

    // Idle lengths for both sides: mostly none or short, now and then long,
    // and once in a while a calm run of beats with no idling at all.
    function automatic int idle_len(inout int calm);
        int roll;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        roll = $urandom_range(99, 0);
        if (roll < 3)
        begin
            calm = $urandom_range(48, 16);
            return 0;
        end
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(3, 1);
        if (roll < 97)
            return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    // Sample driver. A beat accepted at this edge is predicted right away; the
    // next sample goes out after a random gap. The payload only changes when a
    // new sample is put on the wire, so a stalled beat holds still.
    sample_t on_wire;
    logic    offering = 1'b0;
    int      send_gap = 0;
    int      send_calm = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_passes.push_back(advance_flight(on_wire));
                offering = 1'b0;
                send_gap = idle_len(send_calm);
            end
            if (!offering)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_samples.size() != 0)
                begin
                    on_wire = pending_samples.pop_front();
                    offering = 1'b1;
                    time_ms <= on_wire.time_ms;
                    light_level <= on_wire.light_level;
                    height_change <= on_wire.height_change;
                end
            end
            in_valid <= offering;
        end
    end

    // Result side stall. Besides the random stalls, it holds off once for a long
    // stretch while samples keep coming, so the pipeline backs up into in_stall.
    int   stall_left = 0;
    int   stall_calm = 0;
    int   hold_left = 0;
    logic long_hold_done = 1'b0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!long_hold_done && beats_out >= LONG_HOLD_AT)
            begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                stall_left = idle_len(stall_calm);
            end
        end
    end

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            failed = 1'b1;
        end
    endtask

    // Result monitor: each accepted result beat is held against the oldest
    // prediction still waiting.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            beats_out <= beats_out + 1;
            if (expected_passes.size() == 0)
            begin
                $display("%0t: result beat with no prediction waiting", $time);
                failed = 1'b1;
            end
            else
            begin
                want = expected_passes.pop_front();
                compare_field("phase", want.phase, phase);
                compare_field("fire_on", want.fire_on, fire_on);
                compare_field("servo_set", want.servo_set, servo_set);
                compare_field("servo_angle", want.servo_angle, servo_angle);
                compare_field("orient_request", want.orient_request, orient_request);
                compare_field("scan_request", want.scan_request, scan_request);
            end
        end
    end

    task automatic push_sample(input logic [31:0] t, input logic [15:0] light,
                               input logic [23:0] height);
        sample_t s;
        s.time_ms = t;
        s.light_level = light;
        s.height_change = height;
        pending_samples.push_back(s);
    endtask

    // Registers are only touched once every sample has gone through and every
    // result has come back.
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || in_valid || expected_passes.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_BASELINE_LIGHT:     flight_cfg.baseline_light = data[15:0];
            CFG_ARM_TIME:           flight_cfg.arm_time = data;
            CFG_ABORT_TIME:         flight_cfg.abort_time = data;
            CFG_FIRE_DURATION:      flight_cfg.fire_duration = data;
            CFG_LAUNCH_COUNT_LIMIT: flight_cfg.launch_count_limit = data[7:0];
            CFG_LAND_COUNT_LIMIT:   flight_cfg.land_count_limit = data[7:0];
            CFG_HEIGHT_THRESHOLD:   flight_cfg.height_threshold = data[22:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Still in flight for a threshold of 500: anything from the most negative
    // value up to 499.
    function automatic logic [23:0] still_height();
        if ($urandom_range(1, 0) == 1)
            return 24'($urandom_range(499, 0));
        return 24'(32'd0 - $urandom_range(8388608, 1));
    endfunction

    // Since reset happens once, the run is one mission. Each stretch of samples
    // works one phase, and the registers change between stretches.
    initial
    begin
        logic [15:0] baselines [2];
        logic [31:0] light_mid;
        logic [31:0] near_lo;
        logic        land_on_abort;
        int          pick;
        baselines[0] = 16'd0;
        baselines[1] = 16'hFFFF;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Upper bits of the narrow registers are junk and must be dropped.
        // The spare index must change nothing.
        write_reg(CFG_BASELINE_LIGHT, 32'hABCD_2710);
        write_reg(CFG_ARM_TIME, TIME_MAX);
        write_reg(CFG_ABORT_TIME, TIME_MAX);
        write_reg(CFG_FIRE_DURATION, 32'd20000);
        write_reg(CFG_LAUNCH_COUNT_LIMIT, 32'h1234_5605);
        write_reg(CFG_LAND_COUNT_LIMIT, TIME_MAX);
        write_reg(CFG_HEIGHT_THRESHOLD, TIME_MAX);
        write_reg(CFG_SPARE_INDEX, $urandom());

        // Started, with arming at the very top of the time range: field extremes
        // go through without leaving the phase.
        push_sample(32'd0, 16'd0, 24'h80_0000);
        push_sample(32'hFFFF_FFFE, 16'hFFFF, 24'h7F_FFFF);
        repeat (60)
            push_sample($urandom() % TIME_MAX, 16'($urandom()), 24'($urandom()));
        wait_quiet();

        write_reg(CFG_ARM_TIME, ARM_MS);
        repeat (60)
            push_sample($urandom_range(ARM_MS - 1, 0), 16'($urandom()), 24'($urandom()));
        // Time equal to the arm time is enough to arm.
        push_sample(ARM_MS, 16'($urandom()), 24'($urandom()));
        // In rocket with a baseline of 10000: 9000 is exactly on the dark side
        // of the 0.9 line and 9001 is just above it.
        push_sample(ARM_MS + 1, 16'd9000, 24'd0);
        push_sample(ARM_MS + 2, 16'd9001, 24'd0);
        push_sample(ARM_MS + 3, 16'd9000, 24'd0);
        wait_quiet();

        // A launch limit of 255 can never be exceeded, so the rocket phase lasts
        // while light samples stir the counter. Half of them sit near the line.
        write_reg(CFG_LAUNCH_COUNT_LIMIT, 32'd255);
        for (int b = 0; b < 2; b++)
        begin
            write_reg(CFG_BASELINE_LIGHT, {16'($urandom()), baselines[b]});
            light_mid = (32'd9 * baselines[b]) / 32'd10;
            near_lo = (light_mid > 32'd30) ? light_mid - 32'd30 : 32'd0;
            repeat (70)
            begin
                if ($urandom_range(1, 0) == 1)
                    push_sample($urandom(), 16'($urandom()), 24'($urandom()));
                else
                    push_sample($urandom(), 16'($urandom_range(light_mid + 30, near_lo)),
                                24'($urandom()));
            end
            wait_quiet();
        end
        // Light 0 is dark under any baseline and clears the counter.
        push_sample($urandom(), 16'd0, 24'($urandom()));
        wait_quiet();

        // With a limit of 0, the first bright sample only brings the count to 1.
        // The launch comes on the next pass, because the count already exceeds
        // the limit before that pass.
        write_reg(CFG_LAUNCH_COUNT_LIMIT, 32'd0);
        push_sample(32'd77, 16'hFFFF, 24'd0);
        push_sample(LAUNCH_TIME, 16'hFFFF, 24'd0);
        // Flying past the wrap of the time counter. The largest height is not
        // below the largest threshold, and the most negative one is.
        push_sample(32'd5, 16'($urandom()), 24'h7F_FFFF);
        push_sample(32'd6, 16'($urandom()), 24'h80_0000);
        // Almost every height is still, so the counter runs into saturation while
        // a limit of 255 keeps the block flying. Times straddle the fire window.
        repeat (280)
            push_sample(LAUNCH_TIME + $urandom_range(40000, 0), 16'($urandom()),
                        24'($urandom()));
        wait_quiet();

        // A threshold of zero makes only negative heights still. A zero duration
        // keeps the fire output off.
        write_reg(CFG_HEIGHT_THRESHOLD, 32'h0080_0000);
        write_reg(CFG_FIRE_DURATION, 32'd0);
        repeat (100)
            push_sample($urandom(), 16'($urandom()), 24'($urandom()));
        push_sample($urandom(), 16'($urandom()), 24'd0);
        wait_quiet();

        // The counter is back at zero. The mission ends one of two ways, picked
        // at random: either landing and the abort time fall on the same pass
        // (land angle wins), or the abort comes first and forces the landing.
        // The pass just before has a time equal to the abort time, which is
        // not yet past it.
        write_reg(CFG_FIRE_DURATION, TIME_MAX);
        write_reg(CFG_HEIGHT_THRESHOLD, 32'd500);
        write_reg(CFG_LAND_COUNT_LIMIT, 32'd8);
        write_reg(CFG_ABORT_TIME, ABORT_MS);
        land_on_abort = 1'($urandom_range(1, 0));
        repeat (land_on_abort ? 7 : 2)
            push_sample($urandom_range(ABORT_MS - 1, 0), 16'($urandom()), still_height());
        push_sample(ABORT_MS, 16'($urandom()), still_height());
        push_sample(ABORT_MS + 1, 16'($urandom()), still_height());
        // Landed: scan window edges. With the longest duration, the fire output
        // drops only where time minus launch time is all ones.
        push_sample(32'd0, 16'($urandom()), 24'($urandom()));
        push_sample(32'd59999, 16'($urandom()), 24'($urandom()));
        push_sample(32'd60000, 16'($urandom()), 24'($urandom()));
        push_sample(32'd600000, 16'($urandom()), 24'($urandom()));
        push_sample(32'hFFFF_FFEF, 16'($urandom()), 24'($urandom()));
        push_sample(TIME_MAX, 16'($urandom()), 24'($urandom()));
        wait_quiet();

        // Landed for good. An abort time of zero must have no further effect.
        write_reg(CFG_FIRE_DURATION, 32'd30000);
        write_reg(CFG_ABORT_TIME, 32'd0);
        repeat (210)
        begin
            pick = $urandom_range(2, 0);
            if (pick == 0)
                push_sample($urandom(), 16'($urandom()), 24'($urandom()));
            else if (pick == 1)
                push_sample(LAUNCH_TIME + $urandom_range(60000, 0), 16'($urandom()),
                            24'($urandom()));
            else
                push_sample($urandom_range(7157, 0) * 32'd600000 + $urandom_range(120000, 0),
                            16'($urandom()), 24'($urandom()));
        end
        wait_quiet();

        if (!failed)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
design/fps_pkg.sv
design/fps_cfg_regs.sv
design/fps_window_div.sv
design/fps_phase_core.sv
design/flight_phase_sequencer.sv
design/fps_checker.sv
dv/flight_phase_sequencer_test.sv
